/* design/msc_pkg.sv */
`timescale 1ns / 1ps

package msc_pkg;

    // coherence state of one cache line
    typedef enum logic [1:0] {
        ST_I  = 2'd0,
        ST_S  = 2'd1,
        ST_M  = 2'd2,
        ST_SM = 2'd3
    } line_state_t;

    // bus command codes
    typedef enum logic [1:0] {
        K_INVALIDATE = 2'd0,
        K_READ       = 2'd1,
        K_READ_EX    = 2'd2,
        K_UPDATE     = 2'd3
    } kind_t;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming transaction and read its line
        logic execute;   // apply the command, write the line back, load the result
        logic clearing;  // write one line to invalid during the reset sweep
    } msc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;  // sweep is at the last line
    } msc_status_t;

endpackage

/* design/msc_ram.sv */
`timescale 1ns / 1ps

module msc_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single port, registered read that holds while not reading
    always_ff @(posedge clk)
    begin
        if (en && we)
        begin
            mem_reg[addr] <= wdata;
        end
        else if (en)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/msc_ctrl.sv */
`timescale 1ns / 1ps

module msc_ctrl
    import msc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  msc_status_t status,
    output msc_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    // result register can take a new result this cycle
    assign out_free = !out_valid_reg || !out_stall;

    // command decode
    always_comb
    begin
        cmd.capture  = 1'b0;
        cmd.execute  = 1'b0;
        cmd.clearing = 1'b0;
        unique case (state_reg)
            S_CLEAR: cmd.clearing = 1'b1;
            S_IDLE:  cmd.capture  = in_valid;
            S_EXEC:  cmd.execute  = out_free;
            default: ;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.execute)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* design/msc_datapath.sv */
`timescale 1ns / 1ps

module msc_datapath
    import msc_pkg::*;
#(
    parameter int LINE_COUNT   = 256,
    parameter int OFFSET_BITS  = 4,
    parameter int ADDRESS_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  msc_cmd_t    cmd,
    output msc_status_t status,
    input  logic [1:0]  kind,
    input  logic [31:0] address,
    input  logic        from_own_side,
    input  logic [1:0]  new_state,
    output logic        writeback_valid,
    output logic [31:0] writeback_address,
    output logic        fill_valid,
    output logic [31:0] fill_address,
    output logic [1:0]  line_state,
    output logic [31:0] writeback_count,
    output logic [31:0] lost_upgrade_count
);

    localparam int IDX_BITS = $clog2(LINE_COUNT);
    localparam int TAG_RAW  = ADDRESS_BITS - OFFSET_BITS - IDX_BITS;
    localparam int TAG_BITS = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int ENTRY_W  = TAG_BITS + 2;
    localparam logic [32:0] MASK_WIDE = (33'd1 << ADDRESS_BITS) - 33'd1;
    localparam logic [31:0] ADDR_MASK = MASK_WIDE[31:0];

    // block-aligned byte address of a line
    function automatic logic [31:0] line_addr(input logic [TAG_BITS-1:0] tag,
                                              input logic [IDX_BITS-1:0] idx);
        logic [63:0] wide;
        wide = (64'(tag) << (IDX_BITS + OFFSET_BITS)) | (64'(idx) << OFFSET_BITS);
        return wide[31:0] & ADDR_MASK;
    endfunction

    logic [31:0]         addr_m;
    logic [IDX_BITS-1:0] in_idx;
    logic [TAG_BITS-1:0] in_tag;

    kind_t               kind_reg;
    logic [IDX_BITS-1:0] idx_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic                own_reg;
    line_state_t         nst_reg;

    logic [IDX_BITS-1:0] clr_idx_reg, clr_idx_next;
    logic [31:0]         wb_count_reg, wb_count_next;
    logic [31:0]         lost_count_reg, lost_count_next;

    logic                ram_en;
    logic                ram_we;
    logic [IDX_BITS-1:0] ram_addr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;

    line_state_t         st_old;
    logic [TAG_BITS-1:0] tag_old;
    line_state_t         st_new;
    logic [TAG_BITS-1:0] tag_new;
    logic                wb_v;
    logic                fill_v;
    logic                inc_wb;
    logic                inc_lost;
    logic                hit;

    logic                wb_valid_reg;
    logic [31:0]         wb_addr_reg;
    logic                fill_valid_reg;
    logic [31:0]         fill_addr_reg;
    line_state_t         line_state_reg;

    // split the incoming address into index and tag
    assign addr_m = address & ADDR_MASK;
    assign in_idx = IDX_BITS'(addr_m >> OFFSET_BITS);
    assign in_tag = TAG_BITS'(addr_m >> (OFFSET_BITS + IDX_BITS));

    // latch the accepted transaction
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind_t'(kind);
            idx_reg  <= in_idx;
            tag_reg  <= in_tag;
            own_reg  <= from_own_side;
            nst_reg  <= line_state_t'(new_state);
        end
    end

    // line state and tag store
    msc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LINE_COUNT)
    ) u_line_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // ram port selection
    always_comb
    begin
        ram_en    = cmd.clearing || cmd.capture || cmd.execute;
        ram_we    = cmd.clearing || cmd.execute;
        ram_addr  = idx_reg;
        ram_wdata = {st_new, tag_new};
        if (cmd.clearing)
        begin
            ram_addr  = clr_idx_reg;
            ram_wdata = {ST_I, {TAG_BITS{1'b0}}};
        end
        else if (cmd.capture)
        begin
            ram_addr = in_idx;
        end
    end

    // reset sweep counter
    assign clr_idx_next      = cmd.clearing ? clr_idx_reg + 1'b1 : clr_idx_reg;
    assign status.clear_last = (clr_idx_reg == IDX_BITS'(LINE_COUNT - 1));

    // msi transition
    assign st_old  = line_state_t'(ram_rdata[ENTRY_W-1 -: 2]);
    assign tag_old = ram_rdata[TAG_BITS-1:0];
    assign hit     = (st_old != ST_I) && (tag_old == tag_reg);

    always_comb
    begin
        st_new   = st_old;
        tag_new  = tag_old;
        wb_v     = 1'b0;
        fill_v   = 1'b0;
        inc_wb   = 1'b0;
        inc_lost = 1'b0;
        if (kind_reg == K_UPDATE)
        begin
            st_new = nst_reg;
        end
        else if (own_reg)
        begin
            // own command: invalidate completes an upgrade, reads miss and fill
            if (kind_reg == K_INVALIDATE)
            begin
                if (st_old == ST_SM)
                begin
                    st_new = ST_M;
                end
            end
            else
            begin
                if (st_old == ST_M)
                begin
                    wb_v   = 1'b1;
                    inc_wb = 1'b1;
                end
                fill_v  = 1'b1;
                tag_new = tag_reg;
                st_new  = (kind_reg == K_READ) ? ST_S : ST_M;
            end
        end
        else if (hit)
        begin
            // snooped command on a matching valid line
            unique case (kind_reg)
                K_INVALIDATE:
                begin
                    inc_lost = (st_old == ST_SM);
                    st_new   = ST_I;
                end
                K_READ:
                begin
                    if (st_old == ST_M)
                    begin
                        wb_v   = 1'b1;
                        st_new = ST_S;
                    end
                end
                K_READ_EX:
                begin
                    wb_v     = (st_old == ST_M);
                    inc_lost = (st_old == ST_SM);
                    st_new   = ST_I;
                end
                default: ;
            endcase
        end
    end

    // running counters
    assign wb_count_next   = wb_count_reg + 32'(cmd.execute && inc_wb);
    assign lost_count_next = lost_count_reg + 32'(cmd.execute && inc_lost);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg    <= '0;
            wb_count_reg   <= '0;
            lost_count_reg <= '0;
        end
        else
        begin
            clr_idx_reg    <= clr_idx_next;
            wb_count_reg   <= wb_count_next;
            lost_count_reg <= lost_count_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            wb_valid_reg   <= wb_v;
            wb_addr_reg    <= wb_v ? line_addr(tag_old, idx_reg) : 32'd0;
            fill_valid_reg <= fill_v;
            fill_addr_reg  <= fill_v ? line_addr(tag_reg, idx_reg) : 32'd0;
            line_state_reg <= st_new;
        end
    end

    assign writeback_valid    = wb_valid_reg;
    assign writeback_address  = wb_addr_reg;
    assign fill_valid         = fill_valid_reg;
    assign fill_address       = fill_addr_reg;
    assign line_state         = line_state_reg;
    assign writeback_count    = wb_count_reg;
    assign lost_upgrade_count = lost_count_reg;

endmodule

/* design/msc_top_placeholder.sv */
`timescale 1ns / 1ps

module msc_line_view
    import msc_pkg::*;
(
    input  logic [1:0] line_state,
    output logic       owned
);

    // line holds the only valid copy
    assign owned = (line_state_t'(line_state) == ST_M);

endmodule

/* design/msi_snoop_controller.sv */
`timescale 1ns / 1ps

// MSI snoop controller for one direct-mapped cache (states I, S, M and the
// transient SM). Each transaction is a bus command, own or snooped, or a local
// state update; it reads the indexed line's state and tag, applies the MSI
// transition, writes the line back and returns one result with writeback and
// fill requests, the new line state and two wrapping counters. A transaction
// is accepted (line read), then executed (line written back), as set by the
// read-modify-write on the single-port line store; no new one is taken until
// the last has executed, and execute waits while the result register is full
// and stalled. After reset the block sweeps the line store to invalid, one
// line a cycle, stalling input until done. LINE_COUNT must be a power of two.
module msi_snoop_controller
    import msc_pkg::*;
#(
    parameter int LINE_COUNT   = 256,
    parameter int OFFSET_BITS  = 4,
    parameter int ADDRESS_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [31:0] address,
    input  logic        from_own_side,
    input  logic [1:0]  new_state,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        writeback_valid,
    output logic [31:0] writeback_address,
    output logic        fill_valid,
    output logic [31:0] fill_address,
    output logic [1:0]  line_state,
    output logic [31:0] writeback_count,
    output logic [31:0] lost_upgrade_count
);

    msc_cmd_t    cmd;
    msc_status_t status;
    logic        line_owned;

    msc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    msc_datapath #(
        .LINE_COUNT   (LINE_COUNT),
        .OFFSET_BITS  (OFFSET_BITS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .kind               (kind),
        .address            (address),
        .from_own_side      (from_own_side),
        .new_state          (new_state),
        .writeback_valid    (writeback_valid),
        .writeback_address  (writeback_address),
        .fill_valid         (fill_valid),
        .fill_address       (fill_address),
        .line_state         (line_state),
        .writeback_count    (writeback_count),
        .lost_upgrade_count (lost_upgrade_count)
    );

    msc_line_view u_line_view (
        .line_state (line_state),
        .owned      (line_owned)
    );

    // a fill always leaves the line readable or owned
    a_fill_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fill_valid) |-> (line_state == ST_S || line_state == ST_M))
        else $error("fill left line in I or SM");

    // a snooped writeback gives up ownership
    a_snoop_wb_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && writeback_valid && !fill_valid) |-> !line_owned)
        else $error("snooped writeback kept line modified");

    // own writeback count moves only with an own miss that wrote back
    a_wb_count: assert property (@(posedge clk) disable iff (!rst_n)
        (writeback_count != $past(writeback_count))
            |-> (out_valid && writeback_valid && fill_valid))
        else $error("writeback count changed without own writeback");

    // no transaction is taken during the reset sweep
    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clearing |-> in_stall)
        else $error("input accepted during line sweep");

endmodule

/* bench/coherence_monitor.sv */
`timescale 1ns / 1ps

module coherence_monitor
    import msc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [31:0] address,
    input  logic        from_own_side,
    input  logic [1:0]  new_state,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        writeback_valid,
    input  logic [31:0] writeback_address,
    input  logic        fill_valid,
    input  logic [31:0] fill_address,
    input  logic [1:0]  line_state,
    input  logic [31:0] writeback_count,
    input  logic [31:0] lost_upgrade_count,
    output int          mismatches,
    output int          outstanding
);

    localparam int LINES = 256;

    // one result transaction as the block reports it
    typedef struct packed {
        logic        wb_valid;
        logic [31:0] wb_addr;
        logic        fill_valid;
        logic [31:0] fill_addr;
        line_state_t after_state;
        logic [31:0] wb_count;
        logic [31:0] lost_count;
    } coh_result_t;

    // shadow copy of the line store and the counters
    line_state_t line_st [LINES];
    logic [19:0] line_tag [LINES];
    logic [31:0] wb_total;
    logic [31:0] lost_total;

    coh_result_t expected_q [$];

    task automatic report_mismatch(string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // msi transition for one command, updates the shadow state
    function automatic coh_result_t apply_command(kind_t k, logic [31:0] a, logic own,
                                                  line_state_t ns);
        coh_result_t r;
        logic [7:0]  idx;
        logic [19:0] tg;
        line_state_t st;
        r   = '0;
        idx = a[11:4];
        tg  = a[31:12];
        st  = line_st[idx];
        if (k == K_UPDATE)
        begin
            st = ns;
        end
        else if (own)
        begin
            if (k == K_INVALIDATE)
            begin
                if (st == ST_SM)
                    st = ST_M;
            end
            else
            begin
                // own miss: evict a dirty line, then fill
                if (st == ST_M)
                begin
                    r.wb_valid = 1'b1;
                    r.wb_addr  = {line_tag[idx], idx, 4'h0};
                    wb_total   = wb_total + 1;
                end
                r.fill_valid  = 1'b1;
                r.fill_addr   = {tg, idx, 4'h0};
                st            = (k == K_READ) ? ST_S : ST_M;
                line_tag[idx] = tg;
            end
        end
        else if (st != ST_I && line_tag[idx] == tg)
        begin
            // snooped command hitting a valid line
            case (k)
                K_INVALIDATE:
                begin
                    if (st == ST_SM)
                        lost_total = lost_total + 1;
                    st = ST_I;
                end
                K_READ:
                begin
                    if (st == ST_M)
                    begin
                        r.wb_valid = 1'b1;
                        r.wb_addr  = {tg, idx, 4'h0};
                        st         = ST_S;
                    end
                end
                default:
                begin
                    if (st == ST_M)
                    begin
                        r.wb_valid = 1'b1;
                        r.wb_addr  = {tg, idx, 4'h0};
                    end
                    else if (st == ST_SM)
                    begin
                        lost_total = lost_total + 1;
                    end
                    st = ST_I;
                end
            endcase
        end
        line_st[idx]  = st;
        r.after_state = st;
        r.wb_count    = wb_total;
        r.lost_count  = lost_total;
        return r;
    endfunction

    // watch both channels, predict on input, compare on output
    always @(posedge clk or negedge rst_n)
    begin
        coh_result_t got;
        coh_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < LINES; i++)
                line_st[i] = ST_I;
            wb_total   = '0;
            lost_total = '0;
            expected_q.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_q.push_back(apply_command(kind_t'(kind), address, from_own_side,
                                                   line_state_t'(new_state)));
            if (out_valid && !out_stall)
            begin
                got.wb_valid    = writeback_valid;
                got.wb_addr     = writeback_address;
                got.fill_valid  = fill_valid;
                got.fill_addr   = fill_address;
                got.after_state = line_state_t'(line_state);
                got.wb_count    = writeback_count;
                got.lost_count  = lost_upgrade_count;
                if (expected_q.size() == 0)
                begin
                    report_mismatch("result transaction with no command pending");
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.wb_valid !== want.wb_valid)
                        report_mismatch($sformatf("writeback_valid got %b expected %b",
                                                  got.wb_valid, want.wb_valid));
                    if (got.wb_addr !== want.wb_addr)
                        report_mismatch($sformatf("writeback_address got %h expected %h",
                                                  got.wb_addr, want.wb_addr));
                    if (got.fill_valid !== want.fill_valid)
                        report_mismatch($sformatf("fill_valid got %b expected %b",
                                                  got.fill_valid, want.fill_valid));
                    if (got.fill_addr !== want.fill_addr)
                        report_mismatch($sformatf("fill_address got %h expected %h",
                                                  got.fill_addr, want.fill_addr));
                    if (got.after_state !== want.after_state)
                        report_mismatch($sformatf("line_state got %0d expected %0d",
                                                  got.after_state, want.after_state));
                    if (got.wb_count !== want.wb_count)
                        report_mismatch($sformatf("writeback_count got %0d expected %0d",
                                                  got.wb_count, want.wb_count));
                    if (got.lost_count !== want.lost_count)
                        report_mismatch($sformatf("lost_upgrade_count got %0d expected %0d",
                                                  got.lost_count, want.lost_count));
                end
            end
        end
        outstanding = expected_q.size();
    end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
    import msc_pkg::*;

    localparam int RANDOM_ITEMS   = 1625;
    localparam int WATCHDOG_LIMIT = 1500;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    kind_t       kind = K_INVALIDATE;
    logic [31:0] address = '0;
    logic        from_own_side = 1'b0;
    line_state_t new_state = ST_I;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        writeback_valid;
    logic [31:0] writeback_address;
    logic        fill_valid;
    logic [31:0] fill_address;
    logic [1:0]  line_state;
    logic [31:0] writeback_count;
    logic [31:0] lost_upgrade_count;

    int          mismatches;
    int          outstanding;
    int          idle_cycles = 0;
    int          stall_left = 0;
    bit          in_calm = 1'b0;
    bit          out_calm = 1'b0;
    // lines whose tag has been written by an own fill
    bit          tag_seen [256];

    always #5 clk = ~clk;

    msi_snoop_controller dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .kind               (kind),
        .address            (address),
        .from_own_side      (from_own_side),
        .new_state          (new_state),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .writeback_valid    (writeback_valid),
        .writeback_address  (writeback_address),
        .fill_valid         (fill_valid),
        .fill_address       (fill_address),
        .line_state         (line_state),
        .writeback_count    (writeback_count),
        .lost_upgrade_count (lost_upgrade_count)
    );

    coherence_monitor mon (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .kind               (kind),
        .address            (address),
        .from_own_side      (from_own_side),
        .new_state          (new_state),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .writeback_valid    (writeback_valid),
        .writeback_address  (writeback_address),
        .fill_valid         (fill_valid),
        .fill_address       (fill_address),
        .line_state         (line_state),
        .writeback_count    (writeback_count),
        .lost_upgrade_count (lost_upgrade_count),
        .mismatches         (mismatches),
        .outstanding        (outstanding)
    );

    // result side stall: a random hold after each accepted transaction
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            stall_left = out_calm ? 0 : $urandom_range(0, 6);
            out_stall <= (stall_left != 0);
        end
        else if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= (stall_left != 0);
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("msi_snoop_controller test failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // drive one command transaction and wait until it is taken
    task automatic send(kind_t k, logic [31:0] a, logic own, line_state_t ns);
        int         gap;
        logic [7:0] idx;
        gap = in_calm ? 0 : $urandom_range(0, 6);
        idx = a[11:4];
        // never make a line valid before its tag has been written
        if (k == K_UPDATE && ns != ST_I && !tag_seen[idx])
            ns = ST_I;
        if (own && (k == K_READ || k == K_READ_EX))
            tag_seen[idx] = 1'b1;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= k;
        address       <= a;
        from_own_side <= own;
        new_state     <= ns;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    initial
    begin
        logic [7:0]  idx_pool [6];
        logic [19:0] tag_pool [4];
        logic [31:0] a;
        kind_t       k;
        int          pick;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: transitions, tag miss, extremes of the address
        send(K_READ,       32'h0000_0000, 1'b0, ST_I);   // snoop on invalid line
        send(K_INVALIDATE, 32'h0000_0000, 1'b1, ST_I);   // own invalidate on invalid line
        send(K_READ,       32'h0001_2018, 1'b1, ST_I);   // own read fill
        send(K_READ,       32'h0001_2010, 1'b0, ST_I);   // snoop read on shared
        send(K_READ_EX,    32'h7777_7010, 1'b0, ST_I);   // snoop with other tag
        send(K_READ_EX,    32'h0001_201C, 1'b0, ST_I);   // snoop read exclusive on shared
        send(K_READ_EX,    32'h0001_2010, 1'b1, ST_I);   // own read exclusive
        send(K_READ_EX,    32'h00AB_C01F, 1'b1, ST_I);   // dirty eviction
        send(K_READ,       32'h00AB_C010, 1'b0, ST_I);   // snoop read on modified
        send(K_UPDATE,     32'h00AB_C010, 1'b0, ST_SM);
        send(K_INVALIDATE, 32'h00AB_C010, 1'b1, ST_I);   // upgrade completes
        send(K_UPDATE,     32'h00AB_C010, 1'b1, ST_SM);
        send(K_INVALIDATE, 32'h00AB_C014, 1'b0, ST_I);   // lost upgrade on invalidate
        send(K_READ,       32'h00AB_C010, 1'b1, ST_I);
        send(K_UPDATE,     32'h00AB_C010, 1'b0, ST_SM);
        send(K_READ,       32'h00AB_C010, 1'b0, ST_SM);  // snoop read keeps pending upgrade
        send(K_READ_EX,    32'h00AB_C010, 1'b0, ST_I);   // lost upgrade on read exclusive
        send(K_READ_EX,    32'hFFFF_FFFF, 1'b1, ST_I);   // top of the address space
        send(K_INVALIDATE, 32'hFFFF_FFFF, 1'b0, ST_I);   // modified dropped without writeback
        send(K_READ_EX,    32'hFFFF_FFF0, 1'b1, ST_I);
        send(K_READ,       32'hFFFF_FFFF, 1'b1, ST_I);   // own read on modified
        send(K_UPDATE,     32'hFFFF_FFF3, 1'b1, ST_M);
        send(K_READ_EX,    32'hFFFF_FFFF, 1'b0, ST_I);   // snoop read exclusive on modified
        send(K_READ,       32'h0001_2010, 1'b1, ST_I);
        send(K_UPDATE,     32'h0001_2010, 1'b0, ST_I);

        // random: a few hot lines and tags so commands collide
        idx_pool[0] = 8'h00;
        idx_pool[1] = 8'hFF;
        for (int i = 2; i < 6; i++)
            idx_pool[i] = 8'($urandom_range(1, 254));
        tag_pool[0] = 20'h00000;
        tag_pool[1] = 20'hFFFFF;
        tag_pool[2] = 20'($urandom());
        tag_pool[3] = 20'($urandom());
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 64 == 0)
            begin
                in_calm  = ($urandom_range(0, 3) == 0);
                out_calm = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 9) == 0)
                a = $urandom();
            else
                a = {tag_pool[$urandom_range(0, 3)], idx_pool[$urandom_range(0, 5)],
                     4'($urandom_range(0, 15))};
            pick = $urandom_range(0, 9);
            if (pick < 3)
                k = K_INVALIDATE;
            else if (pick < 6)
                k = K_READ;
            else if (pick < 9)
                k = K_READ_EX;
            else
                k = K_UPDATE;
            send(k, a, ($urandom_range(0, 9) < 4), line_state_t'($urandom_range(0, 3)));
        end
        in_valid <= 1'b0;
        in_calm  = 1'b0;

        // drain and settle
        @(posedge clk);
        wait (outstanding == 0);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("msi_snoop_controller test passed");
        else
            $display("msi_snoop_controller test failed");
        $finish;
    end

endmodule
